// File: hw/rtl/cftn_pkg.sv
// cftn_pkg: shared constants, codes and word types of the frequency table normalizer
// used by every module of the block except cftn_ram; depends on nothing else
package cftn_pkg;

  localparam int MAX_CONTEXTS = 4;
  localparam int PROB_TOTAL   = 4096;
  localparam int COUNT_BITS   = 32;
  localparam int NBINS        = 256;

  localparam int SYM_W   = 8;
  localparam int CTX_W   = (MAX_CONTEXTS > 1) ? $clog2(MAX_CONTEXTS) : 1;
  localparam int CNT_W   = $clog2(MAX_CONTEXTS + 1);
  localparam int DEPTH   = MAX_CONTEXTS * NBINS;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int PROB_W  = $clog2(PROB_TOTAL + 1);
  localparam int PROD_W  = COUNT_BITS + PROB_W;
  localparam int RUN_W   = PROD_W + SYM_W + 1;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  // input operations
  localparam logic [1:0] OP_TALLY = 2'd0;
  localparam logic [1:0] OP_NORM  = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_BAD_CTX = 2'd1;
  localparam logic [1:0] ST_NOFIX   = 2'd2;

  // result kinds
  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_READ   = 1'b1;

  // datapath micro-operations
  localparam int UOP_W = 5;
  localparam logic [UOP_W-1:0] DP_NOP      = 5'd0;
  localparam logic [UOP_W-1:0] DP_LATCH    = 5'd1;
  localparam logic [UOP_W-1:0] DP_CLR_STEP = 5'd2;
  localparam logic [UOP_W-1:0] DP_T_RD     = 5'd3;
  localparam logic [UOP_W-1:0] DP_T_WR     = 5'd4;
  localparam logic [UOP_W-1:0] DP_R_RD     = 5'd5;
  localparam logic [UOP_W-1:0] DP_R_OUT    = 5'd6;
  localparam logic [UOP_W-1:0] DP_N_CTX    = 5'd7;
  localparam logic [UOP_W-1:0] DP_N_EMPTY  = 5'd8;
  localparam logic [UOP_W-1:0] DP_N_RD     = 5'd9;
  localparam logic [UOP_W-1:0] DP_N_CHK    = 5'd10;
  localparam logic [UOP_W-1:0] DP_N_WB     = 5'd11;
  localparam logic [UOP_W-1:0] DP_N_ADV    = 5'd12;
  localparam logic [UOP_W-1:0] DP_N_FIX    = 5'd13;
  localparam logic [UOP_W-1:0] DP_N_SRD    = 5'd14;
  localparam logic [UOP_W-1:0] DP_N_SCHK   = 5'd15;
  localparam logic [UOP_W-1:0] DP_N_DONE   = 5'd16;
  localparam logic [UOP_W-1:0] DP_N_FAIL   = 5'd17;
  localparam logic [UOP_W-1:0] DP_N_B0RD   = 5'd18;
  localparam logic [UOP_W-1:0] DP_N_GRD    = 5'd19;
  localparam logic [UOP_W-1:0] DP_N_GCHK   = 5'd20;
  localparam logic [UOP_W-1:0] DP_N_G0     = 5'd21;
  localparam logic [UOP_W-1:0] DP_N_OUT    = 5'd22;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  symbol;
    logic [15:0] context_req;
  } in_word_t;

  typedef struct packed {
    logic        result_kind;
    logic [31:0] freq_value;
    logic [1:0]  status;
  } out_word_t;

  typedef struct packed {
    logic [UOP_W-1:0] uop;
  } dp_cmd_t;

  typedef struct packed {
    logic ctx_bad;
    logic tot_zero;
    logic bin_zero;
    logic div_done;
    logic s_last;
    logic fix_scan;
    logic found;
    logic c_last;
    logic b0_ok;
    logic clr_last;
  } dp_stat_t;

endpackage

// File: hw/rtl/cftn_ram.sv
// cftn_ram: generic simple dual-port ram, one write and one registered read a cycle
// no dependencies
module cftn_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/cftn_div.sv
// cftn_div: iterative restoring divider, one quotient bit per cycle
// depends on cftn_pkg
module cftn_div
  import cftn_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [PROD_W-1:0]     dividend,
  input  logic [COUNT_BITS-1:0] divisor,
  output logic                  done,
  output logic [PROD_W-1:0]     quot
);

  localparam int STEP_W = $clog2(PROD_W + 1);

  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;
  logic [STEP_W-1:0]     cnt_r, cnt_nxt;
  logic [PROD_W-1:0]     q_r, q_nxt;
  logic [COUNT_BITS-1:0] rem_r, rem_nxt;
  logic [COUNT_BITS-1:0] d_r, d_nxt;
  logic [COUNT_BITS:0]   trial;
  logic                  ge;

  // one shift-subtract step
  always_comb begin
    trial    = {rem_r, q_r[PROD_W-1]};
    ge       = (trial >= {1'b0, d_r});
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    d_nxt    = d_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = STEP_W'(PROD_W);
      q_nxt    = dividend;
      rem_nxt  = '0;
      d_nxt    = divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? COUNT_BITS'(trial - {1'b0, d_r}) : trial[COUNT_BITS-1:0];
      q_nxt   = {q_r[PROD_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    d_r   <= d_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// File: hw/rtl/cftn_dp.sv
// cftn_dp: datapath with bin ram, totals, scan counters, divider and result register
// depends on cftn_pkg, cftn_ram and cftn_div
module cftn_dp
  import cftn_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  dp_cmd_t          cmd,
  input  in_word_t         in_word,
  input  logic [CNT_W-1:0] n_ctx,
  output dp_stat_t         stat,
  output logic             out_valid,
  output out_word_t        out_word
);

  localparam logic [RUN_W-1:0]      PROB_RUN = RUN_W'(PROB_TOTAL);
  localparam logic [COUNT_BITS-1:0] PROB_CNT = COUNT_BITS'(PROB_TOTAL);

  in_word_t              item_r, item_nxt;
  logic [CTX_W-1:0]      c_r, c_nxt;
  logic [SYM_W-1:0]      s_r, s_nxt;
  logic [RUN_W-1:0]      run_r, run_nxt;
  logic [SYM_W-1:0]      last_r, last_nxt;
  logic [COUNT_BITS-1:0] lastval_r, lastval_nxt;
  logic                  have_r, have_nxt;
  logic [RUN_W-1:0]      need_r, need_nxt;
  logic [ADDR_W-1:0]     clr_r, clr_nxt;
  logic [1:0]            err_r, err_nxt;
  logic [COUNT_BITS-1:0] tot_r [MAX_CONTEXTS];
  logic [COUNT_BITS-1:0] tot_nxt [MAX_CONTEXTS];
  logic                  ov_r, ov_nxt;
  out_word_t             out_r, out_nxt;

  logic                  we;
  logic [ADDR_W-1:0]     waddr, raddr;
  logic [COUNT_BITS-1:0] wdata, rdata;
  logic                  div_start, div_done;
  logic [PROD_W-1:0]     dividend, quot, v;
  logic [CTX_W-1:0]      item_ctx;
  logic [ADDR_W-1:0]     item_addr;
  logic                  fits_last;

  cftn_ram #(.WIDTH(COUNT_BITS), .DEPTH(DEPTH)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(raddr),
    .rdata(rdata)
  );

  cftn_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (div_start),
    .dividend(dividend),
    .divisor (tot_r[c_r]),
    .done    (div_done),
    .quot    (quot)
  );

  assign item_ctx  = item_r.context_req[CTX_W-1:0];
  assign item_addr = {item_ctx, item_r.symbol};
  assign dividend  = PROD_W'(rdata) * PROD_W'(PROB_TOTAL);
  assign v         = (quot == '0) ? PROD_W'(1) : quot;
  assign fits_last = ((RUN_W + 1)'(lastval_r) + (RUN_W + 1)'(PROB_TOTAL)) > (RUN_W + 1)'(run_r);

  // status back to the controller
  always_comb begin
    stat.ctx_bad  = item_r.context_req >= 16'(n_ctx);
    stat.tot_zero = (tot_r[c_r] == '0);
    stat.bin_zero = (rdata == '0);
    stat.div_done = div_done;
    stat.s_last   = (s_r == {SYM_W{1'b1}});
    stat.fix_scan = have_r && (run_r != PROB_RUN) && !fits_last;
    stat.found    = (cmd.uop == DP_N_GCHK) ? (rdata > COUNT_BITS'(1))
                                           : (RUN_W'(rdata) > need_r);
    stat.c_last   = (CNT_W'(c_r) + CNT_W'(1)) == n_ctx;
    stat.b0_ok    = (rdata != '0);
    stat.clr_last = (clr_r == ADDR_W'(DEPTH - 1));
  end

  // micro-operation decode
  always_comb begin
    item_nxt    = item_r;
    c_nxt       = c_r;
    s_nxt       = s_r;
    run_nxt     = run_r;
    last_nxt    = last_r;
    lastval_nxt = lastval_r;
    have_nxt    = have_r;
    need_nxt    = need_r;
    clr_nxt     = clr_r;
    err_nxt     = err_r;
    tot_nxt     = tot_r;
    ov_nxt      = 1'b0;
    out_nxt     = out_r;
    we          = 1'b0;
    waddr       = '0;
    wdata       = '0;
    raddr       = '0;
    div_start   = 1'b0;
    case (cmd.uop)
      DP_LATCH: begin
        item_nxt = in_word;
        c_nxt    = '0;
      end
      DP_CLR_STEP: begin
        we      = 1'b1;
        waddr   = clr_r;
        clr_nxt = clr_r + 1'b1;
        err_nxt = ST_OK;
        for (int i = 0; i < MAX_CONTEXTS; i++) begin
          tot_nxt[i] = '0;
        end
      end
      DP_T_RD: begin
        if (stat.ctx_bad) begin
          if (err_r == ST_OK) err_nxt = ST_BAD_CTX;
        end else begin
          raddr = item_addr;
        end
      end
      DP_T_WR: begin
        we    = 1'b1;
        waddr = item_addr;
        wdata = (rdata == COUNT_MAX) ? rdata : rdata + 1'b1;
        if (tot_r[item_ctx] != COUNT_MAX) tot_nxt[item_ctx] = tot_r[item_ctx] + 1'b1;
      end
      DP_R_RD: begin
        raddr = item_addr;
      end
      DP_R_OUT: begin
        ov_nxt              = 1'b1;
        out_nxt.result_kind = KIND_READ;
        if (item_r.context_req >= 16'(MAX_CONTEXTS)) begin
          out_nxt.freq_value = '0;
          out_nxt.status     = ST_BAD_CTX;
        end else begin
          out_nxt.freq_value = 32'(rdata);
          out_nxt.status     = ST_OK;
        end
      end
      DP_N_CTX: begin
        s_nxt    = '0;
        run_nxt  = '0;
        have_nxt = 1'b0;
      end
      DP_N_EMPTY: begin
        we           = 1'b1;
        waddr        = {c_r, SYM_W'(0)};
        wdata        = PROB_CNT;
        tot_nxt[c_r] = PROB_CNT;
      end
      DP_N_RD, DP_N_SRD: begin
        raddr = {c_r, s_r};
      end
      DP_N_CHK: begin
        div_start = (rdata != '0);
      end
      DP_N_WB: begin
        we          = 1'b1;
        waddr       = {c_r, s_r};
        wdata       = v[COUNT_BITS-1:0];
        run_nxt     = run_r + RUN_W'(v);
        last_nxt    = s_r;
        lastval_nxt = v[COUNT_BITS-1:0];
        have_nxt    = 1'b1;
      end
      DP_N_ADV: begin
        s_nxt = s_r + 1'b1;
      end
      DP_N_FIX: begin
        if (!have_r) begin
          we    = 1'b1;
          waddr = {c_r, SYM_W'(0)};
          wdata = PROB_CNT;
        end else if (run_r != PROB_RUN) begin
          if (fits_last) begin
            we    = 1'b1;
            waddr = {c_r, last_r};
            wdata = COUNT_BITS'(RUN_W'(lastval_r) + PROB_RUN - run_r);
          end else begin
            need_nxt = run_r - PROB_RUN;
            s_nxt    = '0;
          end
        end
      end
      DP_N_SCHK: begin
        if (stat.found) begin
          we    = 1'b1;
          waddr = {c_r, s_r};
          wdata = COUNT_BITS'(RUN_W'(rdata) - need_r);
        end else begin
          s_nxt = s_r + 1'b1;
        end
      end
      DP_N_DONE: begin
        tot_nxt[c_r] = PROB_CNT;
        c_nxt        = c_r + 1'b1;
      end
      DP_N_FAIL: begin
        if (err_r == ST_OK) err_nxt = ST_NOFIX;
      end
      DP_N_B0RD: begin
        raddr = '0;
        s_nxt = SYM_W'(1);
      end
      DP_N_GRD: begin
        raddr = ADDR_W'(s_r);
      end
      DP_N_GCHK: begin
        if (stat.found) begin
          we    = 1'b1;
          waddr = ADDR_W'(s_r);
          wdata = rdata - 1'b1;
        end else begin
          s_nxt = s_r + 1'b1;
        end
      end
      DP_N_G0: begin
        we    = 1'b1;
        waddr = '0;
        wdata = COUNT_BITS'(1);
      end
      DP_N_OUT: begin
        ov_nxt              = 1'b1;
        out_nxt.result_kind = KIND_STATUS;
        out_nxt.freq_value  = '0;
        out_nxt.status      = err_r;
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r <= '0;
      err_r <= ST_OK;
      ov_r  <= 1'b0;
      for (int i = 0; i < MAX_CONTEXTS; i++) begin
        tot_r[i] <= '0;
      end
    end else begin
      clr_r <= clr_nxt;
      err_r <= err_nxt;
      ov_r  <= ov_nxt;
      tot_r <= tot_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    c_r       <= c_nxt;
    s_r       <= s_nxt;
    run_r     <= run_nxt;
    last_r    <= last_nxt;
    lastval_r <= lastval_nxt;
    have_r    <= have_nxt;
    need_r    <= need_nxt;
    out_r     <= out_nxt;
  end

  assign out_valid = ov_r;
  assign out_word  = out_r;

endmodule

// File: hw/rtl/cftn_ctrl.sv
// cftn_ctrl: controller state machine sequencing the datapath one micro-operation a cycle
// depends on cftn_pkg
module cftn_ctrl
  import cftn_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] in_op,
  input  dp_stat_t   stat,
  output dp_cmd_t    cmd,
  output logic       busy
);

  localparam logic [4:0] S_IDLE   = 5'd0;
  localparam logic [4:0] S_CLR    = 5'd1;
  localparam logic [4:0] S_T_RD   = 5'd2;
  localparam logic [4:0] S_T_WR   = 5'd3;
  localparam logic [4:0] S_R_RD   = 5'd4;
  localparam logic [4:0] S_R_OUT  = 5'd5;
  localparam logic [4:0] S_N_CTX  = 5'd6;
  localparam logic [4:0] S_N_EMP  = 5'd7;
  localparam logic [4:0] S_N_RD   = 5'd8;
  localparam logic [4:0] S_N_CHK  = 5'd9;
  localparam logic [4:0] S_N_DIV  = 5'd10;
  localparam logic [4:0] S_N_WB   = 5'd11;
  localparam logic [4:0] S_N_ADV  = 5'd12;
  localparam logic [4:0] S_N_FIX  = 5'd13;
  localparam logic [4:0] S_N_SRD  = 5'd14;
  localparam logic [4:0] S_N_SCHK = 5'd15;
  localparam logic [4:0] S_N_DONE = 5'd16;
  localparam logic [4:0] S_N_FAIL = 5'd17;
  localparam logic [4:0] S_N_B0RD = 5'd18;
  localparam logic [4:0] S_N_B0CK = 5'd19;
  localparam logic [4:0] S_N_GRD  = 5'd20;
  localparam logic [4:0] S_N_GCHK = 5'd21;
  localparam logic [4:0] S_N_G0   = 5'd22;
  localparam logic [4:0] S_N_OUT  = 5'd23;

  logic [4:0] state_r, state_nxt;

  // next state and micro-operation
  always_comb begin
    state_nxt = state_r;
    cmd.uop   = DP_NOP;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.uop = DP_LATCH;
          case (in_op)
            OP_TALLY: state_nxt = S_T_RD;
            OP_NORM:  state_nxt = S_N_CTX;
            OP_READ:  state_nxt = S_R_RD;
            default:  state_nxt = S_CLR;
          endcase
        end
      end
      S_CLR: begin
        cmd.uop = DP_CLR_STEP;
        if (stat.clr_last) state_nxt = S_IDLE;
      end
      S_T_RD: begin
        cmd.uop   = DP_T_RD;
        state_nxt = stat.ctx_bad ? S_IDLE : S_T_WR;
      end
      S_T_WR: begin
        cmd.uop   = DP_T_WR;
        state_nxt = S_IDLE;
      end
      S_R_RD: begin
        cmd.uop   = DP_R_RD;
        state_nxt = S_R_OUT;
      end
      S_R_OUT: begin
        cmd.uop   = DP_R_OUT;
        state_nxt = S_IDLE;
      end
      S_N_CTX: begin
        cmd.uop   = DP_N_CTX;
        state_nxt = stat.tot_zero ? S_N_EMP : S_N_RD;
      end
      S_N_EMP: begin
        cmd.uop   = DP_N_EMPTY;
        state_nxt = S_N_DONE;
      end
      S_N_RD: begin
        cmd.uop   = DP_N_RD;
        state_nxt = S_N_CHK;
      end
      S_N_CHK: begin
        cmd.uop   = DP_N_CHK;
        state_nxt = stat.bin_zero ? S_N_ADV : S_N_DIV;
      end
      S_N_DIV: begin
        if (stat.div_done) state_nxt = S_N_WB;
      end
      S_N_WB: begin
        cmd.uop   = DP_N_WB;
        state_nxt = S_N_ADV;
      end
      S_N_ADV: begin
        cmd.uop   = DP_N_ADV;
        state_nxt = stat.s_last ? S_N_FIX : S_N_RD;
      end
      S_N_FIX: begin
        cmd.uop   = DP_N_FIX;
        state_nxt = stat.fix_scan ? S_N_SRD : S_N_DONE;
      end
      S_N_SRD: begin
        cmd.uop   = DP_N_SRD;
        state_nxt = S_N_SCHK;
      end
      S_N_SCHK: begin
        cmd.uop = DP_N_SCHK;
        if (stat.found) state_nxt = S_N_DONE;
        else if (stat.s_last) state_nxt = S_N_FAIL;
        else state_nxt = S_N_SRD;
      end
      S_N_DONE: begin
        cmd.uop   = DP_N_DONE;
        state_nxt = stat.c_last ? S_N_B0RD : S_N_CTX;
      end
      S_N_FAIL: begin
        cmd.uop   = DP_N_FAIL;
        state_nxt = S_N_OUT;
      end
      S_N_B0RD: begin
        cmd.uop   = DP_N_B0RD;
        state_nxt = S_N_B0CK;
      end
      S_N_B0CK: begin
        state_nxt = stat.b0_ok ? S_N_OUT : S_N_GRD;
      end
      S_N_GRD: begin
        cmd.uop   = DP_N_GRD;
        state_nxt = S_N_GCHK;
      end
      S_N_GCHK: begin
        cmd.uop = DP_N_GCHK;
        if (stat.found) state_nxt = S_N_G0;
        else if (stat.s_last) state_nxt = S_N_FAIL;
        else state_nxt = S_N_GRD;
      end
      S_N_G0: begin
        cmd.uop   = DP_N_G0;
        state_nxt = S_N_OUT;
      end
      S_N_OUT: begin
        cmd.uop   = DP_N_OUT;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register, reset starts the clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

// File: hw/rtl/context_freq_table_normalizer_unit.sv
// context_freq_table_normalizer_unit: top level with configuration register
// depends on cftn_pkg, cftn_ctrl and cftn_dp
//
// Counts (symbol, context) words into a 256-bin histogram per context and on a
// normalize word scales every context in use to sum to 4096. A word is taken
// when start is high and busy low; one word is handled at a time, all stepping
// through the bin memory with its one write and one registered read port.
// Tally increments one bin, read returns one bin with the
// result strobed on out_valid for one cycle (the receiver cannot stall it),
// clear zeroes the whole memory. Normalize scales every nonzero bin of each
// context in use with one 45-step divide, then runs a remainder scan when
// needed and fixes up bin 0 when it is zero. After reset busy stays high for
// a clearing pass of the memory; configuration writes are taken throughout.
module context_freq_table_normalizer_unit
  import cftn_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  in_word_t    in_word,
  output logic        out_valid,
  output out_word_t   out_word,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [1:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [2:0]       cc_r, cc_nxt;
  logic [CNT_W-1:0] n_ctx;
  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic             ctrl_busy;

  // configuration register, the only one, at byte address zero
  always_comb begin
    cc_nxt = cc_r;
    if (psel && penable && pwrite && (paddr == 2'd0)) begin
      cc_nxt = pwdata[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cc_r <= 3'd1;
    end else begin
      cc_r <= cc_nxt;
    end
  end

  assign prdata = {29'd0, cc_r};
  assign pready = 1'b1;

  // contexts in use, clamped to one and the table count
  always_comb begin
    if (cc_r == 3'd0) n_ctx = CNT_W'(1);
    else if (32'(cc_r) > MAX_CONTEXTS) n_ctx = CNT_W'(MAX_CONTEXTS);
    else n_ctx = CNT_W'(cc_r);
  end

  cftn_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .in_op(in_word.op),
    .stat (stat),
    .cmd  (cmd),
    .busy (ctrl_busy)
  );

  cftn_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_word  (in_word),
    .n_ctx    (n_ctx),
    .stat     (stat),
    .out_valid(out_valid),
    .out_word (out_word)
  );

  assign busy = ctrl_busy;

endmodule
